// File: rtl/core/euzr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and functions for the Euler ZYX to rotation matrix core.
// Holds the quarter-wave sine table built at elaboration. No dependencies.
package euzr_pkg;

    localparam int ANGLE_BITS      = 16;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int SINE_TABLE_BITS = 10;

    localparam int OUT_W   = OUT_FRAC_BITS + 2;
    localparam int WF      = 30;
    localparam int TRIG_W  = WF + 2;
    localparam int PROD_W  = 2 * TRIG_W;
    localparam int SUM_W   = TRIG_W + 1;
    localparam int TAB_Q   = 1 << SINE_TABLE_BITS;
    localparam int IDX_W   = SINE_TABLE_BITS + 1;
    localparam int ROM_W   = WF + 1;
    localparam int RB      = ANGLE_BITS - 2;
    localparam int DROP_SH = (RB > SINE_TABLE_BITS) ? RB - SINE_TABLE_BITS : 0;
    localparam int FILL_SH = (RB > SINE_TABLE_BITS) ? 0 : SINE_TABLE_BITS - RB;
    localparam int OUT_SH  = WF - OUT_FRAC_BITS;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = QPTR_W + 1;

    localparam logic [63:0] HALF_PI_W = 64'd1686629713;
    localparam logic [63:0] ONE_W     = 64'd1 << WF;
    localparam logic [63:0] HALF_W    = 64'd1 << (WF - 1);

    typedef logic [ROM_W-1:0] sine_rom_t [0:TAB_Q];

    typedef struct packed {
        logic signed [TRIG_W-1:0] sy;
        logic signed [TRIG_W-1:0] cy;
        logic signed [TRIG_W-1:0] sp;
        logic signed [TRIG_W-1:0] cp;
        logic signed [TRIG_W-1:0] sr;
        logic signed [TRIG_W-1:0] cr;
    } trig_t;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_status_t;

    function automatic logic [63:0] series_term(input logic [63:0] p, input int d);
        logic [63:0] q;
        unique case (d)
            0:       q = p / 210;
            1:       q = p / 156;
            2:       q = p / 110;
            3:       q = p / 72;
            4:       q = p / 42;
            5:       q = p / 20;
            default: q = p / 6;
        endcase
        return q;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] s;
        for (int i = 0; i <= TAB_Q; i++) begin
            x  = (64'(i) * HALF_PI_W + 64'(TAB_Q >> 1)) >> SINE_TABLE_BITS;
            x2 = (x * x + HALF_W) >> WF;
            t  = ONE_W;
            for (int d = 0; d < 7; d++) begin
                p = (x2 * t + HALF_W) >> WF;
                t = ONE_W - series_term(p, d);
            end
            s = (x * t + HALF_W) >> WF;
            if (s > ONE_W) begin
                s = ONE_W;
            end
            rom[i] = s[ROM_W-1:0];
        end
        rom[0]     = '0;
        rom[TAB_Q] = ONE_W[ROM_W-1:0];
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // Quadrant fold: returns {negate, table index}.
    function automatic logic [IDX_W:0] sine_index(input logic [ANGLE_BITS-1:0] a);
        logic [1:0]  quad;
        logic [31:0] r;
        logic [31:0] k;
        quad = a[ANGLE_BITS-1 -: 2];
        r    = 32'(a[RB-1:0]);
        if (RB > SINE_TABLE_BITS) begin
            k = (r + (32'd1 << ((DROP_SH > 0) ? DROP_SH - 1 : 0))) >> DROP_SH;
        end else begin
            k = r << FILL_SH;
        end
        if (k > 32'(TAB_Q)) begin
            k = 32'(TAB_Q);
        end
        if (quad[0]) begin
            k = 32'(TAB_Q) - k;
        end
        return {quad[1], k[IDX_W-1:0]};
    endfunction

    function automatic logic signed [TRIG_W-1:0] mul_round(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] v;
        v = (p + (PROD_W'(1) <<< (WF - 1))) >>> WF;
        return v[TRIG_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W:0] e;
        logic signed [SUM_W:0] lim;
        e   = (SUM_W + 1)'(v);
        lim = (SUM_W + 1)'(1) <<< OUT_FRAC_BITS;
        if (OUT_SH > 0) begin
            e = (e + ((SUM_W + 1)'(1) <<< ((OUT_SH > 0) ? OUT_SH - 1 : 0))) >>> OUT_SH;
        end
        if (e > lim) begin
            e = lim;
        end
        if (e < -lim) begin
            e = -lim;
        end
        return e[OUT_W-1:0];
    endfunction

endpackage

// File: rtl/core/euzr_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: angle triples in, basis vectors out.
// Depends on euzr_pkg.
interface euzr_angle_if;
    import euzr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] yaw_angle;
    logic [ANGLE_BITS-1:0] pitch_angle;
    logic [ANGLE_BITS-1:0] roll_angle;
    modport source(output valid, output yaw_angle, output pitch_angle, output roll_angle,
                   input ready);
    modport sink(input valid, input yaw_angle, input pitch_angle, input roll_angle,
                 output ready);
endinterface

interface euzr_matrix_if;
    import euzr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] fwd_x;
    logic signed [OUT_W-1:0] fwd_y;
    logic signed [OUT_W-1:0] fwd_z;
    logic signed [OUT_W-1:0] left_x;
    logic signed [OUT_W-1:0] left_y;
    logic signed [OUT_W-1:0] left_z;
    logic signed [OUT_W-1:0] up_x;
    logic signed [OUT_W-1:0] up_y;
    logic signed [OUT_W-1:0] up_z;
    modport source(output valid, output fwd_x, output fwd_y, output fwd_z,
                   output left_x, output left_y, output left_z,
                   output up_x, output up_y, output up_z, input ready);
    modport sink(input valid, input fwd_x, input fwd_y, input fwd_z,
                 input left_x, input left_y, input left_z,
                 input up_x, input up_y, input up_z, output ready);
endinterface

// File: rtl/core/euler_zyx_to_rotation_matrix_core.sv
`timescale 1ns / 1ps
// Z-Y-X Euler angles (binary angles) to forward/left/up basis vectors in signed Q2.14.
// Takes one angle triple per cycle while input ready is high; each result passes through
// the sine ROM read, registered at the transfer edge, then the four-entry queue and the
// product pipeline (pair products, rounding, triple products, sum/round/saturate). Input
// ready follows queue credit, so output stalls back up only after the queue fills.
// Depends on euzr_pkg, euzr_if, euzr_front, euzr_queue, euzr_back.
module euler_zyx_to_rotation_matrix_core (
    input logic           clk,
    input logic           rst_n,
    euzr_angle_if.sink    angles,
    euzr_matrix_if.source matrix
);
    import euzr_pkg::*;

    q_status_t q_stat;
    trig_t     push_data;
    trig_t     head;
    logic      push;
    logic      pop;

    euzr_front u_front (
        .clk(clk), .rst_n(rst_n), .angles(angles), .q_stat(q_stat),
        .push(push), .push_data(push_data)
    );

    euzr_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
        .pop(pop), .head(head), .stat(q_stat)
    );

    euzr_back u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .q_stat(q_stat),
        .pop(pop), .matrix(matrix)
    );
endmodule

// File: rtl/core/euzr_sincos.sv
`timescale 1ns / 1ps
// Sine and cosine of one binary angle from the quarter-wave table ROM.
// Two registered reads per cycle while en is high. Depends on euzr_pkg.
module euzr_sincos (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic        [euzr_pkg::ANGLE_BITS-1:0] angle,
    output logic signed [euzr_pkg::TRIG_W-1:0]     sin_val,
    output logic signed [euzr_pkg::TRIG_W-1:0]     cos_val
);
    import euzr_pkg::*;

    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << RB;

    logic [IDX_W:0]        s_sel;
    logic [IDX_W:0]        c_sel;
    logic [ROM_W-1:0]      s_mag_reg;
    logic [ROM_W-1:0]      c_mag_reg;
    logic                  s_neg_reg;
    logic                  c_neg_reg;

    assign s_sel = sine_index(angle);
    assign c_sel = sine_index(angle + QUARTER);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_mag_reg <= SINE_ROM[s_sel[IDX_W-1:0]];
            c_mag_reg <= SINE_ROM[c_sel[IDX_W-1:0]];
            s_neg_reg <= s_sel[IDX_W];
            c_neg_reg <= c_sel[IDX_W];
        end
    end

    assign sin_val = s_neg_reg ? -$signed({1'b0, s_mag_reg}) : $signed({1'b0, s_mag_reg});
    assign cos_val = c_neg_reg ? -$signed({1'b0, c_mag_reg}) : $signed({1'b0, c_mag_reg});
endmodule

// File: rtl/core/euzr_front.sv
`timescale 1ns / 1ps
// Front end: accepts angle triples against queue credit and looks up sines/cosines.
// Depends on euzr_pkg, euzr_if, euzr_sincos.
module euzr_front (
    input  logic                  clk,
    input  logic                  rst_n,
    euzr_angle_if.sink            angles,
    input  euzr_pkg::q_status_t   q_stat,
    output logic                  push,
    output euzr_pkg::trig_t       push_data
);
    import euzr_pkg::*;

    logic look_v_reg;
    logic look_v_next;
    logic take;

    // Count the lookup in flight against queue room.
    assign angles.ready = (QCNT_W'(look_v_reg) + q_stat.count) < QCNT_W'(QDEPTH);
    assign take         = angles.valid && angles.ready;
    assign look_v_next  = take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            look_v_reg <= 1'b0;
        end
        else
        begin
            look_v_reg <= look_v_next;
        end
    end

    euzr_sincos u_yaw (
        .clk(clk), .en(take), .angle(angles.yaw_angle),
        .sin_val(push_data.sy), .cos_val(push_data.cy)
    );
    euzr_sincos u_pitch (
        .clk(clk), .en(take), .angle(angles.pitch_angle),
        .sin_val(push_data.sp), .cos_val(push_data.cp)
    );
    euzr_sincos u_roll (
        .clk(clk), .en(take), .angle(angles.roll_angle),
        .sin_val(push_data.sr), .cos_val(push_data.cr)
    );

    assign push = look_v_reg;
endmodule

// File: rtl/core/euzr_queue.sv
`timescale 1ns / 1ps
// Short FIFO of trig sets between front and back end.
// Depends on euzr_pkg.
module euzr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  euzr_pkg::trig_t     push_data,
    input  logic                pop,
    output euzr_pkg::trig_t     head,
    output euzr_pkg::q_status_t stat
);
    import euzr_pkg::*;

    trig_t             mem [0:QDEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_pop;

    assign do_pop      = pop && (count_reg != '0);
    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign count_next  = count_reg + QCNT_W'(push) - QCNT_W'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head       = mem[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);
endmodule

// File: rtl/core/euzr_back.sv
`timescale 1ns / 1ps
// Back end: four-stage product pipeline forming the nine matrix entries.
// Stalls as a whole on the output. Depends on euzr_pkg, euzr_if.
module euzr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  euzr_pkg::trig_t     head,
    input  euzr_pkg::q_status_t q_stat,
    output logic                pop,
    euzr_matrix_if.source       matrix
);
    import euzr_pkg::*;

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: raw pair products
    logic signed [PROD_W-1:0] p_cysp_reg, p_sysp_reg, p_cycp_reg, p_sycp_reg, p_cpsr_reg;
    logic signed [PROD_W-1:0] p_cpcr_reg, p_sycr_reg, p_cycr_reg, p_sysr_reg, p_cysr_reg;
    logic signed [TRIG_W-1:0] sr1_reg, cr1_reg, sp1_reg;
    // stage 2: rounded pair products
    logic signed [TRIG_W-1:0] cysp_reg, sysp_reg, fx_reg, fy_reg, lz_reg, uz_reg;
    logic signed [TRIG_W-1:0] sycr_reg, cycr_reg, sysr_reg, cysr_reg;
    logic signed [TRIG_W-1:0] sr2_reg, cr2_reg, sp2_reg;
    // stage 3: raw triple products
    logic signed [PROD_W-1:0] p_a_reg, p_b_reg, p_c_reg, p_d_reg;
    logic signed [TRIG_W-1:0] fx3_reg, fy3_reg, lz3_reg, uz3_reg, sp3_reg;
    logic signed [TRIG_W-1:0] sycr3_reg, cycr3_reg, sysr3_reg, cysr3_reg;
    // stage 4: output register
    logic [OUT_W-1:0] fwd_x_reg, fwd_y_reg, fwd_z_reg, left_x_reg, left_y_reg;
    logic [OUT_W-1:0] left_z_reg, up_x_reg, up_y_reg, up_z_reg;

    logic signed [TRIG_W-1:0] ra, rb, rc, rd;

    assign en  = !v4_reg || matrix.ready;
    assign pop = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= !q_stat.empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign ra = mul_round(p_a_reg);
    assign rb = mul_round(p_b_reg);
    assign rc = mul_round(p_c_reg);
    assign rd = mul_round(p_d_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_cysp_reg <= PROD_W'(head.cy) * PROD_W'(head.sp);
            p_sysp_reg <= PROD_W'(head.sy) * PROD_W'(head.sp);
            p_cycp_reg <= PROD_W'(head.cy) * PROD_W'(head.cp);
            p_sycp_reg <= PROD_W'(head.sy) * PROD_W'(head.cp);
            p_cpsr_reg <= PROD_W'(head.cp) * PROD_W'(head.sr);
            p_cpcr_reg <= PROD_W'(head.cp) * PROD_W'(head.cr);
            p_sycr_reg <= PROD_W'(head.sy) * PROD_W'(head.cr);
            p_cycr_reg <= PROD_W'(head.cy) * PROD_W'(head.cr);
            p_sysr_reg <= PROD_W'(head.sy) * PROD_W'(head.sr);
            p_cysr_reg <= PROD_W'(head.cy) * PROD_W'(head.sr);
            sr1_reg    <= head.sr;
            cr1_reg    <= head.cr;
            sp1_reg    <= head.sp;

            cysp_reg <= mul_round(p_cysp_reg);
            sysp_reg <= mul_round(p_sysp_reg);
            fx_reg   <= mul_round(p_cycp_reg);
            fy_reg   <= mul_round(p_sycp_reg);
            lz_reg   <= mul_round(p_cpsr_reg);
            uz_reg   <= mul_round(p_cpcr_reg);
            sycr_reg <= mul_round(p_sycr_reg);
            cycr_reg <= mul_round(p_cycr_reg);
            sysr_reg <= mul_round(p_sysr_reg);
            cysr_reg <= mul_round(p_cysr_reg);
            sr2_reg  <= sr1_reg;
            cr2_reg  <= cr1_reg;
            sp2_reg  <= sp1_reg;

            p_a_reg   <= PROD_W'(cysp_reg) * PROD_W'(sr2_reg);
            p_b_reg   <= PROD_W'(sysp_reg) * PROD_W'(sr2_reg);
            p_c_reg   <= PROD_W'(cysp_reg) * PROD_W'(cr2_reg);
            p_d_reg   <= PROD_W'(sysp_reg) * PROD_W'(cr2_reg);
            fx3_reg   <= fx_reg;
            fy3_reg   <= fy_reg;
            lz3_reg   <= lz_reg;
            uz3_reg   <= uz_reg;
            sp3_reg   <= sp2_reg;
            sycr3_reg <= sycr_reg;
            cycr3_reg <= cycr_reg;
            sysr3_reg <= sysr_reg;
            cysr3_reg <= cysr_reg;

            fwd_x_reg  <= to_out(SUM_W'(fx3_reg));
            fwd_y_reg  <= to_out(SUM_W'(fy3_reg));
            fwd_z_reg  <= to_out(-SUM_W'(sp3_reg));
            left_x_reg <= to_out(SUM_W'(ra) - SUM_W'(sycr3_reg));
            left_y_reg <= to_out(SUM_W'(rb) + SUM_W'(cycr3_reg));
            left_z_reg <= to_out(SUM_W'(lz3_reg));
            up_x_reg   <= to_out(SUM_W'(rc) + SUM_W'(sysr3_reg));
            up_y_reg   <= to_out(SUM_W'(rd) - SUM_W'(cysr3_reg));
            up_z_reg   <= to_out(SUM_W'(uz3_reg));
        end
    end

    assign matrix.valid  = v4_reg;
    assign matrix.fwd_x  = fwd_x_reg;
    assign matrix.fwd_y  = fwd_y_reg;
    assign matrix.fwd_z  = fwd_z_reg;
    assign matrix.left_x = left_x_reg;
    assign matrix.left_y = left_y_reg;
    assign matrix.left_z = left_z_reg;
    assign matrix.up_x   = up_x_reg;
    assign matrix.up_y   = up_y_reg;
    assign matrix.up_z   = up_z_reg;
endmodule
